FILE: hdl/fixed_format_token_scanner_assert.svh
// Assertion macros of the token scanner, used by its queue module.
`ifndef FIXED_FORMAT_TOKEN_SCANNER_ASSERT_SVH
`define FIXED_FORMAT_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define FFTS_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("ffts: assertion failed");
// Consequence checked in the cycle after the trigger.
`define FFTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ffts: assertion failed");
`else
`define FFTS_ASSERT(lbl, ck, rn, prop)
`define FFTS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hdl/ffts_pkg.sv
// Shared types, codes and helpers of the fixed-format token scanner.
package ffts_pkg;

	localparam int unsigned LINE_BITS_DEF   = 16;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned MAX_TOKS        = 3;

	localparam logic [7:0] LAST_COL_RESET = 8'd72;
	localparam logic [8:0] COMMENT_COL    = 9'd7;
	localparam logic [8:0] FIRST_CODE_COL = 9'd8;

	// input event kinds
	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_EOL  = 2'd1;
	localparam logic [1:0] FUNC_EOF  = 2'd2;

	// token kinds
	localparam logic [2:0] KIND_WORD   = 3'd0;
	localparam logic [2:0] KIND_NUMBER = 3'd1;
	localparam logic [2:0] KIND_STRING = 3'd2;
	localparam logic [2:0] KIND_PERIOD = 3'd3;
	localparam logic [2:0] KIND_LPAREN = 3'd4;
	localparam logic [2:0] KIND_RPAREN = 3'd5;
	localparam logic [2:0] KIND_OP     = 3'd6;
	localparam logic [2:0] KIND_EOF    = 3'd7;

	// operator codes
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_EQ    = 4'd1;
	localparam logic [3:0] OP_PLUS  = 4'd2;
	localparam logic [3:0] OP_STAR  = 4'd3;
	localparam logic [3:0] OP_SLASH = 4'd4;
	localparam logic [3:0] OP_MINUS = 4'd5;
	localparam logic [3:0] OP_GT    = 4'd6;
	localparam logic [3:0] OP_LT    = 4'd7;
	localparam logic [3:0] OP_GE    = 4'd8;
	localparam logic [3:0] OP_LE    = 4'd9;
	localparam logic [3:0] OP_NE    = 4'd10;

	// character codes
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] op;
		logic [7:0] scol;
		logic [7:0] ecol;
	} tok_t;

	// all tokens caused by one input beat; they share one line number
	typedef struct packed {
		logic [1:0]              cnt;
		logic [15:0]             line;
		tok_t [MAX_TOKS-1:0]     toks;
	} bundle_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

FILE: hdl/ffts_channels.sv
// Handshake channel interfaces of the token scanner.
interface ffts_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_code;
	modport source (output valid, func, char_code, input ready);
	modport sink (input valid, func, char_code, output ready);
endinterface

interface ffts_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] last_code_column;
	modport source (output valid, last_code_column, input ready);
	modport sink (input valid, last_code_column, output ready);
endinterface

interface ffts_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [3:0]  operator_code;
	logic [15:0] line_number;
	logic [7:0]  start_column;
	logic [7:0]  end_column;
	logic        last_result;
	modport source (output valid, token_kind, operator_code, line_number, start_column,
		end_column, last_result, input ready);
	modport sink (input valid, token_kind, operator_code, line_number, start_column,
		end_column, last_result, output ready);
endinterface

FILE: hdl/ffts_front.sv
// Front end: column tracking, character classification and the scan state machine.
module ffts_front #(
	parameter int unsigned LINE_BITS = ffts_pkg::LINE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ffts_in_if.sink          in_ch,
	ffts_cfg_if.sink         cfg,
	input  logic             q_full,
	output logic             push,
	output ffts_pkg::bundle_t bundle
);
	import ffts_pkg::*;

	localparam logic [2:0] M_IDLE   = 3'd0;
	localparam logic [2:0] M_WORD   = 3'd1;
	localparam logic [2:0] M_DIGITS = 3'd2;
	localparam logic [2:0] M_NUMBER = 3'd3;
	localparam logic [2:0] M_STRING = 3'd4;
	localparam logic [2:0] M_RELOP  = 3'd5;

	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

	logic [7:0]           lcc_q;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [7:0]           col_q, col_d;
	logic                 comment_q, comment_d;
	logic [2:0]           mode_q, mode_d;
	logic                 quote_q, quote_d;
	logic [7:0]           start_q, start_d;
	logic                 pv_q, pv_d;   // lookahead held
	logic                 ps_q, ps_d;   // lookahead is '.' (digits) or '>' (relop)

	logic                 accept;
	logic [7:0]           c;
	logic [8:0]           nc;
	logic [7:0]           scol;
	logic [7:0]           qchar;
	logic                 do_flush, do_start;
	logic                 t_valid;
	tok_t                 t_tok;
	logic [1:0]           f_cnt, n_f;
	logic [2:0]           f_kind;
	tok_t                 f0, f1;
	logic [LINE_BITS-1:0] ln;
	logic [LINE_BITS+15:0] ln_ext;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign cfg.ready   = 1'b1;
	assign c           = in_ch.char_code;
	assign nc          = {1'b0, col_q} + 9'd1;
	assign scol        = nc[7:0];
	assign qchar       = quote_q ? CH_SQUOTE : CH_DQUOTE;

	// tokens that closing the open token would give, ending at col_q
	assign f_kind = (mode_q == M_WORD) ? KIND_WORD : KIND_NUMBER;
	always_comb begin
		f_cnt = 2'd0;
		f0    = '0;
		f1    = '0;
		case (mode_q)
			M_WORD, M_DIGITS: begin
				if (pv_q) begin
					f_cnt = 2'd2;
					f0    = '{f_kind, OP_NONE, start_q, col_q - 8'd1};
					f1    = ps_q ? tok_t'{KIND_PERIOD, OP_NONE, col_q, col_q}
						: tok_t'{KIND_OP, OP_MINUS, col_q, col_q};
				end else begin
					f_cnt = 2'd1;
					f0    = '{f_kind, OP_NONE, start_q, col_q};
				end
			end
			M_NUMBER: begin
				f_cnt = 2'd1;
				f0    = '{KIND_NUMBER, OP_NONE, start_q, col_q};
			end
			M_STRING: begin
				f_cnt = 2'd1;
				f0    = '{KIND_STRING, OP_NONE, start_q, col_q};
			end
			M_RELOP: begin
				f_cnt = 2'd1;
				f0    = '{KIND_OP, ps_q ? OP_GT : OP_LT, start_q, start_q};
			end
			default: begin
				f_cnt = 2'd0;
			end
		endcase
	end

	// next state and the trailing token of this beat
	always_comb begin
		do_flush  = 1'b0;
		do_start  = 1'b0;
		t_valid   = 1'b0;
		t_tok     = '0;
		line_d    = line_q;
		col_d     = col_q;
		comment_d = comment_q;
		mode_d    = mode_q;
		quote_d   = quote_q;
		start_d   = start_q;
		pv_d      = pv_q;
		ps_d      = ps_q;
		case (in_ch.func)
			FUNC_CHAR: begin
				col_d = nc[8] ? 8'hFF : nc[7:0];
				if (nc == COMMENT_COL) begin
					if (c == CH_STAR || c == CH_SLASH)
						comment_d = 1'b1;
				end else if (nc >= FIRST_CODE_COL && !comment_q) begin
					if (nc > {1'b0, lcc_q} || nc[8]) begin
						// past the code area: close as at end of line
						do_flush = 1'b1;
					end else begin
						case (mode_q)
							M_WORD, M_DIGITS: begin
								if (pv_q) begin
									if (!ps_q && (is_digit(c) || is_letter(c))) begin
										pv_d   = 1'b0;
										mode_d = M_WORD;
									end else if (ps_q && is_digit(c)) begin
										pv_d   = 1'b0;
										mode_d = M_NUMBER;
									end else begin
										do_flush = 1'b1;
										do_start = 1'b1;
									end
								end else if (is_digit(c)) begin
									mode_d = mode_q;
								end else if (is_letter(c)) begin
									mode_d = M_WORD;
								end else if (c == CH_MINUS
									|| (c == CH_DOT && mode_q == M_DIGITS)) begin
									pv_d = 1'b1;
									ps_d = (c == CH_DOT);
								end else begin
									do_flush = 1'b1;
									do_start = 1'b1;
								end
							end
							M_NUMBER: begin
								if (!is_digit(c)) begin
									do_flush = 1'b1;
									do_start = 1'b1;
								end
							end
							M_STRING: begin
								if (pv_q) begin
									if (c == qchar) begin
										pv_d = 1'b0;
									end else begin
										do_flush = 1'b1;
										do_start = 1'b1;
									end
								end else if (c == qchar) begin
									pv_d = 1'b1;
								end
							end
							M_RELOP: begin
								if (c == CH_EQ) begin
									t_valid = 1'b1;
									t_tok   = '{KIND_OP, ps_q ? OP_GE : OP_LE, start_q, scol};
									mode_d  = M_IDLE;
									pv_d    = 1'b0;
									ps_d    = 1'b0;
								end else if (c == CH_GT && !ps_q) begin
									t_valid = 1'b1;
									t_tok   = '{KIND_OP, OP_NE, start_q, scol};
									mode_d  = M_IDLE;
									pv_d    = 1'b0;
									ps_d    = 1'b0;
								end else begin
									do_flush = 1'b1;
									do_start = 1'b1;
								end
							end
							default: begin
								do_start = 1'b1;
							end
						endcase
					end
				end
			end
			FUNC_EOL: begin
				do_flush  = 1'b1;
				if (line_q != LINE_MAX)
					line_d = line_q + 1'b1;
				col_d     = 8'd0;
				comment_d = 1'b0;
			end
			FUNC_EOF: begin
				do_flush  = 1'b1;
				t_valid   = 1'b1;
				t_tok     = '{KIND_EOF, OP_NONE, 8'd0, 8'd0};
				line_d    = '0;
				col_d     = 8'd0;
				comment_d = 1'b0;
				quote_d   = 1'b0;
				start_d   = 8'd0;
			end
			default: begin
				do_flush = 1'b0;
			end
		endcase

		if (do_flush) begin
			mode_d = M_IDLE;
			pv_d   = 1'b0;
			ps_d   = 1'b0;
		end

		// open a new token, or emit a single-character one
		if (do_start) begin
			mode_d = M_IDLE;
			pv_d   = 1'b0;
			ps_d   = 1'b0;
			if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				mode_d  = M_STRING;
				quote_d = (c == CH_SQUOTE);
				start_d = scol;
			end else if (is_digit(c)) begin
				mode_d  = M_DIGITS;
				start_d = scol;
			end else if (is_letter(c)) begin
				mode_d  = M_WORD;
				start_d = scol;
			end else if (c == CH_LT || c == CH_GT) begin
				mode_d  = M_RELOP;
				ps_d    = (c == CH_GT);
				start_d = scol;
			end else if (c == CH_DOT) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_PERIOD, OP_NONE, scol, scol};
			end else if (c == CH_LPAR) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_LPAREN, OP_NONE, scol, scol};
			end else if (c == CH_RPAR) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_RPAREN, OP_NONE, scol, scol};
			end else if (c == CH_EQ) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_OP, OP_EQ, scol, scol};
			end else if (c == CH_PLUS) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_OP, OP_PLUS, scol, scol};
			end else if (c == CH_STAR) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_OP, OP_STAR, scol, scol};
			end else if (c == CH_SLASH) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_OP, OP_SLASH, scol, scol};
			end else if (c == CH_MINUS) begin
				t_valid = 1'b1;
				t_tok   = '{KIND_OP, OP_MINUS, scol, scol};
			end
		end
	end

	// pack flushed tokens then the trailing one
	assign n_f    = do_flush ? f_cnt : 2'd0;
	assign ln     = (line_q == LINE_MAX) ? LINE_MAX : line_q + 1'b1;
	assign ln_ext = {16'd0, ln};
	always_comb begin
		bundle.cnt     = n_f + {1'b0, t_valid};
		bundle.line    = ln_ext[15:0];
		bundle.toks[0] = (n_f != 2'd0) ? f0 : t_tok;
		bundle.toks[1] = (n_f == 2'd2) ? f1 : t_tok;
		bundle.toks[2] = t_tok;
	end
	assign push = accept && (bundle.cnt != 2'd0);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcc_q <= LAST_COL_RESET;
		end else if (cfg.valid) begin
			lcc_q <= cfg.last_code_column;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= '0;
			col_q     <= 8'd0;
			comment_q <= 1'b0;
			mode_q    <= M_IDLE;
			quote_q   <= 1'b0;
			start_q   <= 8'd0;
			pv_q      <= 1'b0;
			ps_q      <= 1'b0;
		end else if (accept) begin
			line_q    <= line_d;
			col_q     <= col_d;
			comment_q <= comment_d;
			mode_q    <= mode_d;
			quote_q   <= quote_d;
			start_q   <= start_d;
			pv_q      <= pv_d;
			ps_q      <= ps_d;
		end
	end

endmodule

FILE: hdl/ffts_queue.sv
// Token bundle queue between the scanner front end and the token emitter.
`include "fixed_format_token_scanner_assert.svh"
module ffts_queue #(
	parameter int unsigned DEPTH = ffts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ffts_pkg::bundle_t wr_data,
	input  logic              pop,
	output ffts_pkg::bundle_t rd_data,
	output logic              full,
	output logic              empty
);
	import ffts_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`FFTS_ASSERT(a_no_overflow, clk, arst_n, push |-> !full)
	`FFTS_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty)
	`FFTS_ASSERT(a_bundle_nonempty, clk, arst_n, push |-> (wr_data.cnt != 2'd0))
	`FFTS_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

FILE: hdl/ffts_back.sv
// Back end: takes bundles apart and drives the token output register.
module ffts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ffts_pkg::bundle_t head,
	output logic              pop,
	ffts_out_if.source        out_ch
);
	import ffts_pkg::*;

	logic [1:0]  idx_q;
	logic        ov_q;
	tok_t        tok_q;
	logic [15:0] line_q;
	logic        last_q;

	logic        load;
	logic        take;
	logic        is_last;
	tok_t        cur;

	assign load    = !ov_q || out_ch.ready;
	assign take    = load && !q_empty;
	assign cur     = head.toks[idx_q];
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = take && is_last;

	assign out_ch.valid         = ov_q;
	assign out_ch.token_kind    = tok_q.kind;
	assign out_ch.operator_code = tok_q.op;
	assign out_ch.line_number   = line_q;
	assign out_ch.start_column  = tok_q.scol;
	assign out_ch.end_column    = tok_q.ecol;
	assign out_ch.last_result   = last_q;

	// output valid and position inside the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load)
				ov_q <= !q_empty;
			if (take)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= cur;
			line_q <= (cur.kind == KIND_EOF) ? 16'd0 : head.line;
			last_q <= is_last;
		end
	end

endmodule

FILE: hdl/fixed_format_token_scanner.sv
// Fixed-format source token scanner: top level.
// Takes one input beat (a character, end of line or end of file) per clock and
// classifies it in the front end in that same cycle; the one to three tokens it
// causes, if any, travel as one bundle through a QUEUE_DEPTH-entry queue to the
// back end, which sends one token beat per clock while the output is ready
// through a registered output. Input stays ready while the queue has room, so
// with the output ready a stream in which each beat gives at most one token runs
// at one beat per cycle; a beat that gives two or three tokens sends that many
// output beats, and the input stalls once the queue fills. A token passes the
// queue and then the output register. The last code column register may be
// written whenever the scanner is idle and is back at 72 after reset.
module fixed_format_token_scanner #(
	parameter int unsigned LINE_BITS   = ffts_pkg::LINE_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = ffts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ffts_in_if.sink    in_ch,
	ffts_cfg_if.sink   cfg,
	ffts_out_if.source out_ch
);
	import ffts_pkg::*;

	bundle_t push_bundle;
	bundle_t head;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;

	ffts_front #(
		.LINE_BITS (LINE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.bundle (push_bundle)
	);

	ffts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_bundle),
		.pop     (pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	ffts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

FILE: sim/tb_fixed_format_token_scanner.sv
`timescale 1ns / 100ps
// Testbench of the fixed-format token scanner: queued source events, token predictor, checker.
module tb_fixed_format_token_scanner;
	import ffts_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_GAP       = 16;

	localparam logic [15:0] LINE_MAX    = 16'hFFFF;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam logic [7:0]  CH_COMMA    = 8'h2C;
	localparam logic [7:0]  CH_SEMI     = 8'h3B;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_NUMBER, SCAN_STRING, SCAN_RELOP
	} scan_mode_t;

	// one source event with the idle cycles the sender spends before it
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] code;
		logic [4:0] gap;
	} src_event_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  op;
		logic [15:0] line;
		logic [7:0]  scol;
		logic [7:0]  ecol;
		logic        last;
	} token_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffts_in_if  in_ch ();
	ffts_cfg_if cfg_ch ();
	ffts_out_if out_ch ();

	fixed_format_token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_ch),
		.out_ch (out_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	// scanner model state
	logic [7:0]  code_limit;
	logic [15:0] lines_done;
	int          col_seen;
	logic        in_comment;
	scan_mode_t  scan_mode;
	logic        apos_quote;
	int          tok_first;
	logic [7:0]  held_char;
	logic        held_valid;
	token_beat_t beat_tokens[$];
	token_beat_t expected_tokens[$];

	// stimulus state
	src_event_t  pending_events[$];
	logic [7:0]  line_buf[$];
	bit          send_quiet;
	int unsigned events_queued;
	int unsigned events_accepted;

	// driver state
	src_event_t  staged_event;
	bit          staged;
	int          gap_left;

	// monitor state
	token_beat_t got_token;
	token_beat_t want_token;
	int          rx_wait;
	int          rx_hold;
	bit          rx_fast;
	bit          hold_off_request;
	bit          next_ready;
	int unsigned mismatches;
	int unsigned tokens_checked;

	int          stall_cycles;

	function automatic logic num_char(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic alpha_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	// tokens of one event share the line count at the time they are made; an end-of-file token gets line 0
	function automatic void push_token(input logic [2:0] kind, input logic [3:0] op,
		input int s, input int e);
		token_beat_t t;
		if (beat_tokens.size() >= MAX_TOKS)
			return;
		t.kind = kind;
		t.op   = op;
		t.line = (kind == KIND_EOF) ? 16'd0 :
			((lines_done == LINE_MAX) ? LINE_MAX : lines_done + 16'd1);
		t.scol = (kind == KIND_EOF) ? 8'd0 : 8'(s);
		t.ecol = (kind == KIND_EOF) ? 8'd0 : 8'(e);
		t.last = 1'b0;
		beat_tokens.insert(beat_tokens.size(), t);
	endfunction

	function automatic void to_idle();
		scan_mode  = SCAN_IDLE;
		held_valid = 1'b0;
		held_char  = 8'd0;
	endfunction

	function automatic void clear_scan_state();
		lines_done = 16'd0;
		col_seen   = 0;
		in_comment = 1'b0;
		apos_quote = 1'b0;
		tok_first  = 0;
		to_idle();
	endfunction

	// first character of a token; single-character tokens go out at once
	function automatic void open_token(input logic [7:0] c, input int col);
		to_idle();
		if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			scan_mode  = SCAN_STRING;
			apos_quote = (c == CH_SQUOTE);
			tok_first  = col;
		end else if (num_char(c)) begin
			scan_mode = SCAN_DIGITS;
			tok_first = col;
		end else if (alpha_char(c)) begin
			scan_mode = SCAN_WORD;
			tok_first = col;
		end else if (c == CH_LT || c == CH_GT) begin
			scan_mode = SCAN_RELOP;
			held_char = c;
			tok_first = col;
		end else begin
			case (c)
				CH_DOT:   push_token(KIND_PERIOD, OP_NONE, col, col);
				CH_LPAR:  push_token(KIND_LPAREN, OP_NONE, col, col);
				CH_RPAR:  push_token(KIND_RPAREN, OP_NONE, col, col);
				CH_EQ:    push_token(KIND_OP, OP_EQ, col, col);
				CH_PLUS:  push_token(KIND_OP, OP_PLUS, col, col);
				CH_STAR:  push_token(KIND_OP, OP_STAR, col, col);
				CH_SLASH: push_token(KIND_OP, OP_SLASH, col, col);
				CH_MINUS: push_token(KIND_OP, OP_MINUS, col, col);
				default: ;
			endcase
		end
	endfunction

	// close the open token; cc is the last scanned column
	function automatic void close_token(input int cc);
		logic [2:0] kind;
		case (scan_mode)
			SCAN_WORD, SCAN_DIGITS: begin
				kind = (scan_mode == SCAN_WORD) ? KIND_WORD : KIND_NUMBER;
				if (held_valid) begin
					push_token(kind, OP_NONE, tok_first, cc - 1);
					if (held_char == CH_DOT)
						push_token(KIND_PERIOD, OP_NONE, cc, cc);
					else
						push_token(KIND_OP, OP_MINUS, cc, cc);
				end else begin
					push_token(kind, OP_NONE, tok_first, cc);
				end
			end
			SCAN_NUMBER: push_token(KIND_NUMBER, OP_NONE, tok_first, cc);
			SCAN_STRING: push_token(KIND_STRING, OP_NONE, tok_first, cc);
			SCAN_RELOP: push_token(KIND_OP, (held_char == CH_GT) ? OP_GT : OP_LT,
				tok_first, tok_first);
			default: ;
		endcase
		to_idle();
	endfunction

	// one code-area character against the open token
	function automatic void scan_code_char(input logic [7:0] c, input int col);
		logic [7:0] q;
		case (scan_mode)
			SCAN_WORD, SCAN_DIGITS: begin
				if (held_valid) begin
					if (held_char == CH_MINUS && (num_char(c) || alpha_char(c))) begin
						held_valid = 1'b0;
						scan_mode  = SCAN_WORD;
					end else if (held_char == CH_DOT && num_char(c)) begin
						held_valid = 1'b0;
						scan_mode  = SCAN_NUMBER;
					end else begin
						close_token(col - 1);
						open_token(c, col);
					end
				end else if (num_char(c)) begin
				end else if (alpha_char(c)) begin
					scan_mode = SCAN_WORD;
				end else if (c == CH_MINUS || (c == CH_DOT && scan_mode == SCAN_DIGITS)) begin
					held_valid = 1'b1;
					held_char  = c;
				end else begin
					close_token(col - 1);
					open_token(c, col);
				end
			end
			SCAN_NUMBER: begin
				if (!num_char(c)) begin
					close_token(col - 1);
					open_token(c, col);
				end
			end
			SCAN_STRING: begin
				q = apos_quote ? CH_SQUOTE : CH_DQUOTE;
				if (held_valid) begin
					// a doubled quote stays inside the string
					if (c == q) begin
						held_valid = 1'b0;
					end else begin
						close_token(col - 1);
						open_token(c, col);
					end
				end else if (c == q) begin
					held_valid = 1'b1;
					held_char  = c;
				end
			end
			SCAN_RELOP: begin
				if (c == CH_EQ) begin
					push_token(KIND_OP, (held_char == CH_GT) ? OP_GE : OP_LE, tok_first, col);
					to_idle();
				end else if (c == CH_GT && held_char == CH_LT) begin
					push_token(KIND_OP, OP_NE, tok_first, col);
					to_idle();
				end else begin
					close_token(col - 1);
					open_token(c, col);
				end
			end
			default: open_token(c, col);
		endcase
	endfunction

	// expected tokens of one accepted source event
	function automatic void predict_tokens(input logic [1:0] func, input logic [7:0] c);
		int nc;
		token_beat_t t;
		beat_tokens.delete();
		if (func == FUNC_CHAR) begin
			nc = col_seen + 1;
			if (nc == int'(COMMENT_COL)) begin
				if (c == CH_STAR || c == CH_SLASH)
					in_comment = 1'b1;
			end else if (nc >= int'(FIRST_CODE_COL) && !in_comment) begin
				if (nc > int'(code_limit) || nc > 255)
					close_token(col_seen);
				else
					scan_code_char(c, nc);
			end
			col_seen = (nc > 255) ? 255 : nc;
		end else if (func == FUNC_EOL) begin
			close_token(col_seen);
			if (lines_done != LINE_MAX)
				lines_done++;
			col_seen   = 0;
			in_comment = 1'b0;
		end else if (func == FUNC_EOF) begin
			close_token(col_seen);
			push_token(KIND_EOF, OP_NONE, 0, 0);
			clear_scan_state();
		end
		if (beat_tokens.size() != 0) begin
			t = beat_tokens[beat_tokens.size() - 1];
			t.last = 1'b1;
			beat_tokens[beat_tokens.size() - 1] = t;
		end
		foreach (beat_tokens[i])
			expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
	endfunction

	function automatic void queue_event(input logic [1:0] func, input logic [7:0] code);
		src_event_t ev;
		ev.func = func;
		ev.code = code;
		ev.gap  = send_quiet ? 5'd0 : 5'($urandom_range(0, MAX_GAP));
		pending_events.insert(pending_events.size(), ev);
		events_queued++;
	endfunction

	function automatic void add_char(input logic [7:0] c);
		line_buf.insert(line_buf.size(), c);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic void send_buffer(input logic [1:0] closing);
		foreach (line_buf[i])
			queue_event(FUNC_CHAR, line_buf[i]);
		queue_event(closing, 8'($urandom_range(0, 255)));
	endfunction

	function automatic void queue_line(input string s, input logic [1:0] closing);
		line_buf.delete();
		add_text(s);
		send_buffer(closing);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_alnum();
		case ($urandom_range(0, 2))
			0: return 8'h41 + 8'($urandom_range(0, 25));
			1: return 8'h61 + 8'($urandom_range(0, 25));
			default: return pick_digit();
		endcase
	endfunction

	// one random lexical piece, mostly well formed, sometimes glued to the next
	function automatic void add_fragment();
		logic [7:0] q;
		logic [7:0] punct[10];
		punct = '{CH_DOT, CH_LPAR, CH_RPAR, CH_EQ, CH_PLUS, CH_STAR, CH_SLASH, CH_MINUS,
			CH_COMMA, CH_SEMI};
		case ($urandom_range(0, 12))
			0, 1: begin
				add_char(8'h41 + 8'($urandom_range(0, 25)));
				repeat ($urandom_range(0, 7)) begin
					if ($urandom_range(0, 4) == 0)
						add_char(CH_MINUS);
					add_char(pick_alnum());
				end
				if ($urandom_range(0, 7) == 0)
					add_char(CH_MINUS);
			end
			2: begin
				// digit-led run that may turn into a word
				repeat ($urandom_range(1, 4)) add_char(pick_digit());
				case ($urandom_range(0, 2))
					0: add_char(pick_alnum());
					1: begin
						add_char(CH_MINUS);
						add_char(pick_alnum());
					end
					default: ;
				endcase
			end
			3: begin
				repeat ($urandom_range(1, 5)) add_char(pick_digit());
				if ($urandom_range(0, 1) == 1) begin
					add_char(CH_DOT);
					repeat ($urandom_range(1, 3)) add_char(pick_digit());
				end
			end
			4: begin
				// dot after digits with no digit behind it
				repeat ($urandom_range(1, 3)) add_char(pick_digit());
				add_char(CH_DOT);
				if ($urandom_range(0, 1) == 1)
					add_char(CH_DOT);
				else
					add_char(8'h41 + 8'($urandom_range(0, 25)));
			end
			5: begin
				q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
				add_char(q);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: begin
							add_char(q);
							add_char(q);
						end
						1: add_char((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
						2: add_char(CH_SPACE);
						default: add_char(pick_alnum());
					endcase
				end
				// now and then left open
				if ($urandom_range(0, 7) != 0)
					add_char(q);
			end
			6: begin
				add_char(($urandom_range(0, 1) == 1) ? CH_LT : CH_GT);
				case ($urandom_range(0, 3))
					0: add_char(CH_EQ);
					1: add_char(CH_GT);
					2: add_char(CH_LT);
					default: ;
				endcase
			end
			7, 8: add_char(punct[$urandom_range(0, 9)]);
			9: add_char(8'($urandom_range(0, 255)));
			10: add_char(($urandom_range(0, 1) == 1) ? CH_SPACE :
				CH_TAB + 8'($urandom_range(0, 4)));
			default: begin
				add_char(pick_alnum());
				add_char(CH_MINUS);
				if ($urandom_range(0, 1) == 1)
					add_char(CH_MINUS);
				add_char(pick_alnum());
			end
		endcase
		if ($urandom_range(0, 3) != 0)
			add_char(CH_SPACE);
	endfunction

	// random fixed-format lines until about n events are queued, closed by end of file
	function automatic void run_random_lines(input int unsigned n);
		int unsigned first;
		int target;
		first = events_queued;
		while (events_queued - first < n) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 29) == 0)
				queue_event(FUNC_UNUSED, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 19) == 0) begin
				queue_event(FUNC_EOL, 8'($urandom_range(0, 255)));
			end else begin
				line_buf.delete();
				repeat (6) add_char(8'($urandom_range(0, 255)));
				case ($urandom_range(0, 9))
					0: add_char(CH_STAR);
					1: add_char(CH_SLASH);
					2: add_char(8'($urandom_range(0, 255)));
					default: add_char(CH_SPACE);
				endcase
				target = $urandom_range(8, 90);
				while (line_buf.size() < target)
					add_fragment();
				send_buffer(($urandom_range(0, 14) == 0) ? FUNC_EOF : FUNC_EOL);
			end
		end
		queue_event(FUNC_EOF, 8'($urandom_range(0, 255)));
	endfunction

	task automatic wait_for_quiet();
		while (events_accepted != events_queued || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_code_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.last_code_column <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		code_limit = v;
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("%0t ns: token %0d: %s", $time, tokens_checked, what);
	endtask

	// source driver: one queued event per beat, idle gap drawn per event
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_tokens(in_ch.func, in_ch.char_code);
				events_accepted++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (!staged && pending_events.size() != 0) begin
					staged_event = pending_events.pop_front();
					staged = 1'b1;
					gap_left = staged_event.gap;
				end
				if (staged && gap_left == 0) begin
					in_ch.valid <= 1'b1;
					in_ch.func <= staged_event.func;
					in_ch.char_code <= staged_event.code;
					staged = 1'b0;
				end else begin
					in_ch.valid <= 1'b0;
					if (staged)
						gap_left--;
				end
			end
		end
	end

	// token monitor: compare each beat with the oldest expectation, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got_token.kind = out_ch.token_kind;
				got_token.op   = out_ch.operator_code;
				got_token.line = out_ch.line_number;
				got_token.scol = out_ch.start_column;
				got_token.ecol = out_ch.end_column;
				got_token.last = out_ch.last_result;
				if (expected_tokens.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat kind %0d line %0d col %0d",
						got_token.kind, got_token.line, got_token.scol));
				end else begin
					want_token = expected_tokens.pop_front();
					if (got_token.kind != want_token.kind)
						flag_mismatch($sformatf("kind %0d, want %0d",
							got_token.kind, want_token.kind));
					if (got_token.op != want_token.op)
						flag_mismatch($sformatf("operator %0d, want %0d",
							got_token.op, want_token.op));
					if (got_token.line != want_token.line)
						flag_mismatch($sformatf("line %0d, want %0d",
							got_token.line, want_token.line));
					if (got_token.scol != want_token.scol)
						flag_mismatch($sformatf("start column %0d, want %0d",
							got_token.scol, want_token.scol));
					if (got_token.ecol != want_token.ecol)
						flag_mismatch($sformatf("end column %0d, want %0d",
							got_token.ecol, want_token.ecol));
					if (got_token.last != want_token.last)
						flag_mismatch($sformatf("last flag %0d, want %0d",
							got_token.last, want_token.last));
				end
				tokens_checked++;
				rx_wait = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
				if ($urandom_range(0, 19) == 0)
					rx_fast = !rx_fast;
			end
			if (hold_off_request) begin
				rx_hold = HOLD_CYCLES;
				hold_off_request = 1'b0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				next_ready = 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			out_ch.ready <= next_ready;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
				(out_ch.valid && out_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("watchdog: no beat for %0d cycles, %0d tokens outstanding",
						stall_cycles, expected_tokens.size());
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_CHAR;
		in_ch.char_code = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.last_code_column = LAST_COL_RESET;
		out_ch.ready = 1'b0;
		code_limit = LAST_COL_RESET;
		clear_scan_state();
		send_quiet = 1'b0;
		rx_fast = 1'b0;
		hold_off_request = 1'b0;
		rx_wait = 0;
		rx_hold = 0;
		staged = 1'b0;
		gap_left = 0;
		stall_cycles = 0;
		events_queued = 0;
		events_accepted = 0;
		mismatches = 0;
		tokens_checked = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines at the reset code area: token shapes, comments, open string
		queue_line("000100 MOVE WS-A 7-UP 12AB 3.14 5. 6-", FUNC_EOL);
		queue_line("000200 'IT''S' \"Q\"\"\" ()=+*/- < > <= >= <> ,;~", FUNC_EOL);
		queue_line("000300*COMMENT 'X'", FUNC_EOL);
		queue_line("000400/A", FUNC_EOL);
		queue_line("000500 'OPEN", FUNC_EOL);
		queue_event(FUNC_UNUSED, 8'hFF);
		queue_line("000600 Z", FUNC_EOF);
		wait_for_quiet();

		// random lines against a long output hold-off
		hold_off_request = 1'b1;
		run_random_lines(60);
		wait_for_quiet();

		// widest code area: word with a held hyphen cut at column 255, then saturation
		set_code_limit(8'd255);
		line_buf.delete();
		add_text("000100 ");
		repeat (245) add_char(CH_SPACE);
		add_text("AB-CD");
		send_buffer(FUNC_EOL);
		wait_for_quiet();

		// narrowest code area, then a limit below the code start
		set_code_limit(FIRST_CODE_COL[7:0]);
		queue_line("000100 AB 'C'", FUNC_EOL);
		wait_for_quiet();
		set_code_limit(8'd3);
		queue_line("000200 WORD", FUNC_EOF);
		wait_for_quiet();

		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
